### rtl/pbnc_pkg.sv
// Shared constants, payload types and codes for the palette blend and
// nearest-color search block. Depends on nothing.
`default_nettype none

package pbnc_pkg;

   localparam int CHAN_W  = 8;
   localparam int IDX_W   = 6;
   localparam int RATIO_W = 9;
   localparam int DIST_W  = 18;

   localparam int DEFAULT_PALETTE_ENTRIES = 64;

   localparam logic [RATIO_W-1:0] Q_ONE = RATIO_W'(256);

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_BLEND = 1'b1;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } rgb_type;

   typedef struct packed {
      logic               operation;
      logic [IDX_W-1:0]   entry_index;
      logic [CHAN_W-1:0]  entry_red;
      logic [CHAN_W-1:0]  entry_green;
      logic [CHAN_W-1:0]  entry_blue;
      logic [IDX_W-1:0]   first_color;
      logic [IDX_W-1:0]   second_color;
      logic [RATIO_W-1:0] ratio_q8;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]  best_index;
      logic [CHAN_W-1:0] blend_red;
      logic [CHAN_W-1:0] blend_green;
      logic [CHAN_W-1:0] blend_blue;
      logic [DIST_W-1:0] best_distance;
   } rsp_type;

endpackage

`default_nettype wire

### rtl/pbnc_if.sv
// Valid/ready channel interfaces for request and response traffic.
// Depends on pbnc_pkg for the payload types.
`default_nettype none

interface pbnc_req_if;
   import pbnc_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface pbnc_rsp_if;
   import pbnc_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/palette_blend_nearest_color.sv
// Palette blend and nearest-color search, top level.
// A write request updates the palette on acceptance; a blend request passes
// through the read, mix, scan and load states before its response is given.
// Throughput: one request at a time; the palette scan reads one entry per
// cycle through the single memory read port and the shared distance unit.
// Reset clears all palette valid bits, so every entry reads as black.
// Depends on pbnc_pkg, pbnc_if and pbnc_dist_unit.
`default_nettype none

module palette_blend_nearest_color #(
   parameter int PALETTE_ENTRIES = pbnc_pkg::DEFAULT_PALETTE_ENTRIES
) (
   input wire logic     clock,
   input wire logic     reset,
   pbnc_req_if.sink     req_chan,
   pbnc_rsp_if.source   rsp_chan
);
   import pbnc_pkg::*;

   localparam int AW = (PALETTE_ENTRIES > 2) ? $clog2(PALETTE_ENTRIES) : 1;
   localparam logic [AW-1:0] LAST = AW'(PALETTE_ENTRIES - 1);

   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ_A,
      S_READ_B,
      S_MIX,
      S_SCAN,
      S_LOAD
   } state_type;

   state_type state_ff, state_in;

   rgb_type                  mem [PALETTE_ENTRIES];
   logic [PALETTE_ENTRIES-1:0] valid_ff;
   rgb_type                  rd_data_ff;
   logic                     rd_vld_ff;
   logic [AW-1:0]            rd_addr;
   rgb_type                  rd_rgb;

   logic [AW-1:0]      first_addr_ff, second_addr_ff;
   logic               first_ok_ff, second_ok_ff;
   logic [RATIO_W-1:0] ratio_ff;
   rgb_type            c1_ff;
   rgb_type            c2;
   rgb_type            blend_ff;
   logic [1:0]         ch_ff;

   logic [AW-1:0]      issue_cnt_ff;
   logic               issue_done_ff;
   logic               rd_live_ff;
   logic [AW-1:0]      rd_idx_ff;
   logic [AW-1:0]      dist_idx_ff;
   logic               dist_valid;
   logic [DIST_W-1:0]  scan_dist;

   logic [AW-1:0]      best_idx_ff;
   logic [DIST_W-1:0]  best_dist_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   logic               req_fire, wr_en;
   logic               load_ok;
   logic [CHAN_W-1:0]  mix_a, mix_b, mix_out;
   logic signed [9:0]  mix_diff;
   logic signed [9:0]  mix_q;
   logic signed [19:0] mix_prod;
   logic signed [19:0] mix_acc;

   assign req_chan.ready = (state_ff == S_IDLE) && !reset;
   assign req_fire = req_chan.valid && req_chan.ready;
   assign wr_en = req_fire && (req_chan.data.operation == OP_WRITE) &&
                  (int'(req_chan.data.entry_index) < PALETTE_ENTRIES);
   assign load_ok = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      case (state_ff)
         S_READ_A: rd_addr = first_addr_ff;
         S_SCAN:   rd_addr = issue_cnt_ff;
         default:  rd_addr = second_addr_ff;
      endcase
   end

   assign rd_rgb = rd_vld_ff ? rd_data_ff : '0;
   assign c2 = second_ok_ff ? rd_rgb : '0;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[AW'(req_chan.data.entry_index)] <= '{red:   req_chan.data.entry_red,
                                                  green: req_chan.data.entry_green,
                                                  blue:  req_chan.data.entry_blue};
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[AW'(req_chan.data.entry_index)] <= 1'b1;
      end
      rd_vld_ff <= valid_ff[rd_addr];
   end

   always_comb begin
      case (ch_ff)
         CH_RED: begin
            mix_a = c1_ff.red;
            mix_b = c2.red;
         end
         CH_GREEN: begin
            mix_a = c1_ff.green;
            mix_b = c2.green;
         end
         default: begin
            mix_a = c1_ff.blue;
            mix_b = c2.blue;
         end
      endcase
      mix_diff = $signed({2'b00, mix_b}) - $signed({2'b00, mix_a});
      mix_q    = $signed({1'b0, ratio_ff});
      mix_prod = mix_diff * mix_q;
      mix_acc  = mix_prod + $signed({4'b0000, mix_a, 8'h80});
      mix_out  = (mix_acc[19:16] != 4'd0) ? {CHAN_W{1'b1}} : mix_acc[15:8];
   end

   pbnc_dist_unit u_dist (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rd_live_ff),
      .entry     (rd_rgb),
      .target    (blend_ff),
      .out_valid (dist_valid),
      .distance  (scan_dist)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire && req_chan.data.operation == OP_BLEND) state_in = S_READ_A;
         end
         S_READ_A: state_in = S_READ_B;
         S_READ_B: state_in = S_MIX;
         S_MIX: begin
            if (ch_ff == CH_BLUE) state_in = S_SCAN;
         end
         S_SCAN: begin
            if (dist_valid && dist_idx_ff == LAST) state_in = S_LOAD;
         end
         S_LOAD: begin
            if (load_ok) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         rd_live_ff    <= 1'b0;
         issue_done_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rd_live_ff <= (state_ff == S_SCAN) && !issue_done_ff;
         if (state_ff == S_MIX) begin
            issue_done_ff <= 1'b0;
         end else if (state_ff == S_SCAN && issue_cnt_ff == LAST) begin
            issue_done_ff <= 1'b1;
         end
         if (state_ff == S_LOAD && load_ok) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end

      if (req_fire) begin
         first_addr_ff  <= AW'(req_chan.data.first_color);
         second_addr_ff <= AW'(req_chan.data.second_color);
         first_ok_ff    <= int'(req_chan.data.first_color) < PALETTE_ENTRIES;
         second_ok_ff   <= int'(req_chan.data.second_color) < PALETTE_ENTRIES;
         ratio_ff       <= (req_chan.data.ratio_q8 > Q_ONE) ? Q_ONE
                                                           : req_chan.data.ratio_q8;
      end

      if (state_ff == S_READ_B) begin
         c1_ff <= first_ok_ff ? rd_rgb : '0;
         ch_ff <= CH_RED;
      end

      if (state_ff == S_MIX) begin
         case (ch_ff)
            CH_RED:   blend_ff.red   <= mix_out;
            CH_GREEN: blend_ff.green <= mix_out;
            default:  blend_ff.blue  <= mix_out;
         endcase
         ch_ff        <= ch_ff + 2'd1;
         issue_cnt_ff <= '0;
      end

      if (state_ff == S_SCAN && !issue_done_ff && issue_cnt_ff != LAST) begin
         issue_cnt_ff <= issue_cnt_ff + 1'b1;
      end
      rd_idx_ff   <= issue_cnt_ff;
      dist_idx_ff <= rd_idx_ff;

      if (dist_valid && (dist_idx_ff == '0 || scan_dist < best_dist_ff)) begin
         best_dist_ff <= scan_dist;
         best_idx_ff  <= dist_idx_ff;
      end

      if (state_ff == S_LOAD && load_ok) begin
         rsp_data_ff.best_index    <= IDX_W'(best_idx_ff);
         rsp_data_ff.blend_red     <= blend_ff.red;
         rsp_data_ff.blend_green   <= blend_ff.green;
         rsp_data_ff.blend_blue    <= blend_ff.blue;
         rsp_data_ff.best_distance <= best_dist_ff;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   a_rsp_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_LOAD))
      else $error("response raised outside load step");

   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (!dist_valid && !rd_live_ff))
      else $error("scan pipeline busy while idle");

   a_scan_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOAD) |-> issue_done_ff)
      else $error("load reached before all entries issued");

   a_hold_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |=> $stable(rsp_data_ff))
      else $error("pending response changed");

endmodule

`default_nettype wire

### rtl/pbnc_dist_unit.sv
// Shared squared-RGB-distance unit, one entry per cycle, registered output.
// Depends on pbnc_pkg for rgb_type and widths.
`default_nettype none

module pbnc_dist_unit (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      in_valid,
   input  wire pbnc_pkg::rgb_type         entry,
   input  wire pbnc_pkg::rgb_type         target,
   output logic                           out_valid,
   output logic [pbnc_pkg::DIST_W-1:0]    distance
);
   import pbnc_pkg::*;

   logic [CHAN_W-1:0]   diff_r, diff_g, diff_b;
   logic [2*CHAN_W-1:0] sq_r, sq_g, sq_b;
   logic [DIST_W-1:0]   dist_in;
   logic [DIST_W-1:0]   dist_ff;
   logic                valid_ff;

   function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                   input logic [CHAN_W-1:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   always_comb begin
      diff_r  = abs_diff(entry.red, target.red);
      diff_g  = abs_diff(entry.green, target.green);
      diff_b  = abs_diff(entry.blue, target.blue);
      sq_r    = {{CHAN_W{1'b0}}, diff_r} * {{CHAN_W{1'b0}}, diff_r};
      sq_g    = {{CHAN_W{1'b0}}, diff_g} * {{CHAN_W{1'b0}}, diff_g};
      sq_b    = {{CHAN_W{1'b0}}, diff_b} * {{CHAN_W{1'b0}}, diff_b};
      dist_in = DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      dist_ff <= dist_in;
   end

   assign out_valid = valid_ff;
   assign distance  = dist_ff;

endmodule

`default_nettype wire

### bench/tb_palette_blend_nearest_color.sv
// Self-checking bench for palette_blend_nearest_color: palette writes and
// blend/search requests with random gaps and stalls, checked against a predictor.
// Depends on pbnc_pkg, pbnc_if and the block's RTL.
`timescale 1ns / 1ps

module tb_palette_blend_nearest_color;
   import pbnc_pkg::*;

   localparam int PALETTE_N    = DEFAULT_PALETTE_ENTRIES;
   localparam int RANDOM_ITEMS = 1700;
   localparam int SETTLE_TICKS = PALETTE_N + 16;

   class blend_tracker;
      rgb_type     shades[PALETTE_N];
      rsp_type     awaited[$];
      int unsigned errors;

      function new();
         foreach (shades[i]) shades[i] = '0;
         errors = 0;
      endfunction

      function logic [CHAN_W-1:0] mix_channel(int unsigned a, int unsigned b,
                                               int unsigned q);
         int unsigned v;
         v = (a * (256 - q) + b * q + 128) >> 8;
         return (v > 255) ? CHAN_W'(255) : CHAN_W'(v);
      endfunction

      function int unsigned sq_gap(int unsigned a, int unsigned b);
         int unsigned g;
         g = (a > b) ? a - b : b - a;
         return g * g;
      endfunction

      function rsp_type predict_blend(req_type r);
         rgb_type     c1;
         rgb_type     c2;
         int unsigned q;
         int unsigned d;
         int unsigned best_d;
         rsp_type     p;
         c1 = shades[r.first_color];
         c2 = shades[r.second_color];
         q = (r.ratio_q8 > Q_ONE) ? 256 : r.ratio_q8;
         p.blend_red   = mix_channel(c1.red, c2.red, q);
         p.blend_green = mix_channel(c1.green, c2.green, q);
         p.blend_blue  = mix_channel(c1.blue, c2.blue, q);
         p.best_index  = '0;
         best_d = 0;
         for (int i = 0; i < PALETTE_N; i++) begin
            d = sq_gap(p.blend_red, shades[i].red) +
                sq_gap(p.blend_green, shades[i].green) +
                sq_gap(p.blend_blue, shades[i].blue);
            if (i == 0 || d < best_d) begin
               best_d = d;
               p.best_index = IDX_W'(i);
            end
         end
         p.best_distance = DIST_W'(best_d);
         return p;
      endfunction

      function void report(string what, int unsigned want, int unsigned got);
         errors++;
         if (errors <= 10)
            $display("mismatch %s: expected %0d, got %0d", what, want, got);
      endfunction

      function void note_request(req_type r);
         if (r.operation == OP_BLEND)
            awaited.push_back(predict_blend(r));
         else
            shades[r.entry_index] = {r.entry_red, r.entry_green, r.entry_blue};
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (awaited.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected response: index %0d distance %0d",
                        got.best_index, got.best_distance);
            return;
         end
         want = awaited.pop_front();
         if (got.best_index !== want.best_index)
            report("best_index", want.best_index, got.best_index);
         if (got.blend_red !== want.blend_red)
            report("blend_red", want.blend_red, got.blend_red);
         if (got.blend_green !== want.blend_green)
            report("blend_green", want.blend_green, got.blend_green);
         if (got.blend_blue !== want.blend_blue)
            report("blend_blue", want.blend_blue, got.blend_blue);
         if (got.best_distance !== want.best_distance)
            report("best_distance", want.best_distance, got.best_distance);
      endfunction

      function int unsigned pending();
         return awaited.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   steady = 1'b0;

   blend_tracker tracker = new();

   pbnc_req_if req_bus ();
   pbnc_rsp_if rsp_bus ();

   palette_blend_nearest_color u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #8000000;
      $display("status: fail");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            tracker.note_request(req_bus.data);
         if (rsp_bus.valid && rsp_bus.ready)
            tracker.check_response(rsp_bus.data);
      end
   end

   initial begin
      int unsigned stall;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 15);
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   function automatic req_type noise_request();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      return raw[$bits(req_type)-1:0];
   endfunction

   function automatic logic [CHAN_W-1:0] pick_level();
      logic [CHAN_W-1:0] levels[6] = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255};
      if ($urandom_range(0, 9) < 3)
         return levels[$urandom_range(0, 5)];
      return CHAN_W'($urandom_range(0, 255));
   endfunction

   function automatic logic [RATIO_W-1:0] pick_ratio();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll == 0)
         return RATIO_W'($urandom_range(257, 511));
      if (roll == 1)
         return ($urandom_range(0, 1) != 0) ? RATIO_W'(0) : Q_ONE;
      return RATIO_W'($urandom_range(0, 256));
   endfunction

   task automatic send_request(req_type r);
      int unsigned gap;
      gap = steady ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.data  <= r;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic write_entry(int unsigned idx, logic [23:0] rgb);
      req_type r;
      r = noise_request();
      r.operation   = OP_WRITE;
      r.entry_index = IDX_W'(idx);
      {r.entry_red, r.entry_green, r.entry_blue} = rgb;
      send_request(r);
   endtask

   task automatic blend_pair(int unsigned a, int unsigned b, int unsigned q);
      req_type r;
      r = noise_request();
      r.operation    = OP_BLEND;
      r.first_color  = IDX_W'(a);
      r.second_color = IDX_W'(b);
      r.ratio_q8     = RATIO_W'(q);
      send_request(r);
   endtask

   task automatic drain_responses();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   initial begin
      req_type r;
      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.data  <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // cleared palette: every entry ties at distance zero
      blend_pair(0, 63, 128);
      write_entry(63, 24'hFFFFFF);
      write_entry(1, 24'hFF0000);
      write_entry(2, 24'h00FF00);
      write_entry(3, 24'h0000FF);
      write_entry(5, 24'h808080);
      write_entry(6, 24'h010101);
      write_entry(7, 24'h808080);
      write_entry(10, 24'h0A0A0A);
      write_entry(11, 24'h0C0C0C);
      blend_pair(63, 63, 0);
      blend_pair(1, 63, 256);
      blend_pair(1, 2, 511);
      blend_pair(1, 2, 257);
      blend_pair(1, 2, 128);
      blend_pair(6, 0, 128);
      blend_pair(5, 5, 0);
      blend_pair(10, 11, 128);
      blend_pair(1, 3, 1);
      blend_pair(2, 3, 255);
      write_entry(0, 24'hFFFFFF);
      blend_pair(0, 0, 0);
      blend_pair(0, 63, 128);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 150 == 0)
            steady = ($urandom_range(0, 3) == 0);
         if (n == RANDOM_ITEMS / 2)
            drain_responses();
         r = noise_request();
         if ($urandom_range(0, 99) < 40) begin
            r.operation   = OP_WRITE;
            r.entry_red   = pick_level();
            r.entry_green = pick_level();
            r.entry_blue  = pick_level();
         end else begin
            r.operation = OP_BLEND;
            r.ratio_q8  = pick_ratio();
         end
         send_request(r);
      end

      drain_responses();
      repeat (SETTLE_TICKS) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
